/* rtl/rpg_pkg.sv */
// Shared types and constants for the rainbow pixel generator.
// No dependencies; every other file in the block imports this package.

package rpg_pkg;

    // Field widths of the input and result beats
    localparam int PIX_W     = 12;
    localparam int ELAPSED_W = 32;
    localparam int FADE_W    = 9;
    localparam int CHAN_W    = 8;

    // Configuration registers
    localparam int CYCLE_W    = 16;
    localparam int LEDS_W     = 13;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CYCLE_MS  = 1'b0,
        CFG_LED_COUNT = 1'b1
    } t_cfg_idx;

    localparam logic [CYCLE_W-1:0] CYCLE_MS_RESET  = 16'd5000;
    localparam logic [LEDS_W-1:0]  LED_COUNT_RESET = 13'd1;

    // Long division: partial remainder width and restoring steps per stage
    localparam int DIV_W           = 16;
    localparam int STEPS_PER_STAGE = 4;

    // Hue sectors, named by the colour span each one covers
    typedef logic [2:0] t_sector;
    localparam t_sector SEC_R2Y = 3'd0;
    localparam t_sector SEC_Y2G = 3'd1;
    localparam t_sector SEC_G2C = 3'd2;
    localparam t_sector SEC_C2B = 3'd3;
    localparam t_sector SEC_B2M = 3'd4;
    localparam t_sector SEC_M2R = 3'd5;

    typedef logic [CHAN_W-1:0] t_chan;
    localparam t_chan CHAN_MAX  = 8'hFF;
    localparam t_chan CHAN_ZERO = 8'h00;

    localparam logic [FADE_W-1:0] FADE_OFF = 9'd0;

endpackage

/* rtl/rainbow_pixel_generator_core.sv */
// Top level of the rainbow pixel generator: configuration registers, divider pipeline
// and colour back end. Depends on rpg_pkg, rpg_div_stage and rpg_hue2rgb.
//
// Usage:
//   Input beat: pixel index, elapsed milliseconds and fade level, taken at a rising
//   edge with start high and busy low. busy is high through reset and in the first
//   cycle after it, so from then on a beat can be taken on every clock.
//   Result beat: green, red and blue, shown for exactly one cycle with o_strobe high.
//   The receiver cannot hold results off, and the block never stalls.
//   Throughput: one pixel per clock. From accept to strobe a beat passes through the
//   two restoring dividers (elapsed time by cycle_ms, pixel index by led_count) that
//   run side by side, up to four quotient bits per stage, followed by three colour stages.
//   Configuration: write cycle_ms (index 0) and led_count (index 1) through the plain
//   write port while no pixel is in flight; a value of zero is taken as one.
//   Reset: synchronous, active low; clears the pipeline valid flags and loads cycle_ms = 5000
//   and led_count = 1.

module rainbow_pixel_generator_core #(
    parameter int HUE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rpg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [rpg_pkg::PIX_W-1:0]          i_pixel_index,
    input  logic [rpg_pkg::ELAPSED_W-1:0]      i_elapsed_ms,
    input  logic [rpg_pkg::FADE_W-1:0]         i_fade_level,
    output logic                               o_strobe,
    output logic [rpg_pkg::CHAN_W-1:0]         o_green,
    output logic [rpg_pkg::CHAN_W-1:0]         o_red,
    output logic [rpg_pkg::CHAN_W-1:0]         o_blue
);
    import rpg_pkg::*;

    localparam int NUM_W   = ELAPSED_W + HUE_BITS;
    localparam int NSTEPS  = ELAPSED_W + HUE_BITS;
    localparam int NSTAGES = (NSTEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    logic                r_busy;
    logic [CYCLE_W-1:0]  r_cyc_div;
    logic [LEDS_W-1:0]   r_led_div;
    logic [DIV_W-1:0]    led_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_cyc_div <= CYCLE_MS_RESET;
            r_led_div <= LED_COUNT_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                // store zero as one so the dividers never see a zero divisor
                unique case (i_cfg_idx)
                    CFG_CYCLE_MS: begin
                        r_cyc_div <= (i_cfg_data == '0) ? CYCLE_W'(1) : i_cfg_data;
                    end
                    CFG_LED_COUNT: begin
                        r_led_div <= (i_cfg_data[LEDS_W-1:0] == '0) ? LEDS_W'(1)
                                                                    : i_cfg_data[LEDS_W-1:0];
                    end
                endcase
            end
        end
    end

    assign busy    = r_busy;
    assign led_div = {{(DIV_W-LEDS_W){1'b0}}, r_led_div};

    // Divider pipeline taps, stage 0 being the accepted beat
    logic                s_valid [NSTAGES+1];
    logic [FADE_W-1:0]   s_fade  [NSTAGES+1];
    logic [NUM_W-1:0]    s_t_num [NSTAGES+1];
    logic [DIV_W-1:0]    s_t_rem [NSTAGES+1];
    logic [HUE_BITS-1:0] s_t_quo [NSTAGES+1];
    logic [NUM_W-1:0]    s_p_num [NSTAGES+1];
    logic [DIV_W-1:0]    s_p_rem [NSTAGES+1];
    logic [HUE_BITS-1:0] s_p_quo [NSTAGES+1];

    assign s_valid[0] = start && !r_busy;
    assign s_fade[0]  = i_fade_level;
    assign s_t_num[0] = {i_elapsed_ms, {HUE_BITS{1'b0}}};
    assign s_t_rem[0] = '0;
    assign s_t_quo[0] = '0;
    assign s_p_num[0] = {{(ELAPSED_W-PIX_W){1'b0}}, i_pixel_index, {HUE_BITS{1'b0}}};
    assign s_p_rem[0] = '0;
    assign s_p_quo[0] = '0;

    for (genvar s = 0; s < NSTAGES; s++) begin : g_div
        localparam int LEFT = NSTEPS - s * STEPS_PER_STAGE;
        localparam int NST  = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

        rpg_div_stage #(
            .HUE_BITS (HUE_BITS),
            .STEPS    (NST)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cyc_div (r_cyc_div),
            .i_led_div (led_div),
            .i_valid   (s_valid[s]),
            .i_fade    (s_fade[s]),
            .i_t_num   (s_t_num[s]),
            .i_t_rem   (s_t_rem[s]),
            .i_t_quo   (s_t_quo[s]),
            .i_p_num   (s_p_num[s]),
            .i_p_rem   (s_p_rem[s]),
            .i_p_quo   (s_p_quo[s]),
            .o_valid   (s_valid[s+1]),
            .o_fade    (s_fade[s+1]),
            .o_t_num   (s_t_num[s+1]),
            .o_t_rem   (s_t_rem[s+1]),
            .o_t_quo   (s_t_quo[s+1]),
            .o_p_num   (s_p_num[s+1]),
            .o_p_rem   (s_p_rem[s+1]),
            .o_p_quo   (s_p_quo[s+1])
        );
    end

    rpg_hue2rgb #(
        .HUE_BITS (HUE_BITS)
    ) u_hue2rgb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid[NSTAGES]),
        .i_t_quo  (s_t_quo[NSTAGES]),
        .i_p_quo  (s_p_quo[NSTAGES]),
        .i_fade   (s_fade[NSTAGES]),
        .o_strobe (o_strobe),
        .o_green  (o_green),
        .o_red    (o_red),
        .o_blue   (o_blue)
    );

endmodule

/* rtl/rpg_div_stage.sv */
// One register stage of the two parallel restoring dividers (time hue and pixel offset).
// Depends on rpg_pkg.

module rpg_div_stage #(
    parameter int HUE_BITS = 16,
    parameter int STEPS    = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [rpg_pkg::DIV_W-1:0]                  i_cyc_div,
    input  logic [rpg_pkg::DIV_W-1:0]                  i_led_div,
    input  logic                                       i_valid,
    input  logic [rpg_pkg::FADE_W-1:0]                 i_fade,
    input  logic [rpg_pkg::ELAPSED_W+HUE_BITS-1:0]     i_t_num,
    input  logic [rpg_pkg::DIV_W-1:0]                  i_t_rem,
    input  logic [HUE_BITS-1:0]                        i_t_quo,
    input  logic [rpg_pkg::ELAPSED_W+HUE_BITS-1:0]     i_p_num,
    input  logic [rpg_pkg::DIV_W-1:0]                  i_p_rem,
    input  logic [HUE_BITS-1:0]                        i_p_quo,
    output logic                                       o_valid,
    output logic [rpg_pkg::FADE_W-1:0]                 o_fade,
    output logic [rpg_pkg::ELAPSED_W+HUE_BITS-1:0]     o_t_num,
    output logic [rpg_pkg::DIV_W-1:0]                  o_t_rem,
    output logic [HUE_BITS-1:0]                        o_t_quo,
    output logic [rpg_pkg::ELAPSED_W+HUE_BITS-1:0]     o_p_num,
    output logic [rpg_pkg::DIV_W-1:0]                  o_p_rem,
    output logic [HUE_BITS-1:0]                        o_p_quo
);
    import rpg_pkg::*;

    localparam int NUM_W = ELAPSED_W + HUE_BITS;

    // Returns {quotient bit, new remainder}
    function automatic logic [DIV_W:0] div_step(
        input logic [DIV_W-1:0] rem,
        input logic             nb,
        input logic [DIV_W-1:0] d
    );
        logic [DIV_W:0] t;
        logic [DIV_W:0] diff;
        t    = {rem, nb};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, diff[DIV_W-1:0]};
        end else begin
            return {1'b0, t[DIV_W-1:0]};
        end
    endfunction

    logic                r_valid;
    logic [FADE_W-1:0]   r_fade;
    logic [NUM_W-1:0]    r_t_num, r_p_num, n_t_num, n_p_num;
    logic [DIV_W-1:0]    r_t_rem, r_p_rem, n_t_rem, n_p_rem;
    logic [HUE_BITS-1:0] r_t_quo, r_p_quo, n_t_quo, n_p_quo;

    always_comb begin
        logic [DIV_W:0] t_res;
        logic [DIV_W:0] p_res;
        n_t_num = i_t_num;
        n_t_rem = i_t_rem;
        n_t_quo = i_t_quo;
        n_p_num = i_p_num;
        n_p_rem = i_p_rem;
        n_p_quo = i_p_quo;
        for (int s = 0; s < STEPS; s++) begin
            t_res   = div_step(n_t_rem, n_t_num[NUM_W-1], i_cyc_div);
            p_res   = div_step(n_p_rem, n_p_num[NUM_W-1], i_led_div);
            n_t_rem = t_res[DIV_W-1:0];
            n_p_rem = p_res[DIV_W-1:0];
            // keep only the low quotient bits: the whole turns drop out
            n_t_quo = {n_t_quo[HUE_BITS-2:0], t_res[DIV_W]};
            n_p_quo = {n_p_quo[HUE_BITS-2:0], p_res[DIV_W]};
            n_t_num = {n_t_num[NUM_W-2:0], 1'b0};
            n_p_num = {n_p_num[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fade  <= i_fade;
        r_t_num <= n_t_num;
        r_t_rem <= n_t_rem;
        r_t_quo <= n_t_quo;
        r_p_num <= n_p_num;
        r_p_rem <= n_p_rem;
        r_p_quo <= n_p_quo;
    end

    assign o_valid = r_valid;
    assign o_fade  = r_fade;
    assign o_t_num = r_t_num;
    assign o_t_rem = r_t_rem;
    assign o_t_quo = r_t_quo;
    assign o_p_num = r_p_num;
    assign o_p_rem = r_p_rem;
    assign o_p_quo = r_p_quo;

endmodule

/* rtl/rpg_hue2rgb.sv */
// Three-stage hue to RGB back end: hue sum and sector split, ramp rounding, fade scaling.
// Depends on rpg_pkg.

module rpg_hue2rgb #(
    parameter int HUE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [HUE_BITS-1:0]         i_t_quo,
    input  logic [HUE_BITS-1:0]         i_p_quo,
    input  logic [rpg_pkg::FADE_W-1:0]  i_fade,
    output logic                        o_strobe,
    output rpg_pkg::t_chan              o_green,
    output rpg_pkg::t_chan              o_red,
    output rpg_pkg::t_chan              o_blue
);
    import rpg_pkg::*;

    localparam int H6_W   = HUE_BITS + 3;
    localparam int RAMP_W = HUE_BITS + 9;
    localparam logic [RAMP_W-1:0] HALF = RAMP_W'(1) << (HUE_BITS - 1);
    localparam logic [RAMP_W-1:0] ONE  = RAMP_W'(1) << HUE_BITS;

    function automatic t_chan fade_scale(input t_chan c, input logic [7:0] f);
        logic [15:0] p;
        p = {8'd0, c} * {8'd0, f} + 16'd128;
        return p[15:8];
    endfunction

    // Stage 1: hue and hue * 6
    logic                r1_valid;
    logic [H6_W-1:0]     r1_h6, n1_h6;
    logic [FADE_W-1:0]   r1_fade;

    always_comb begin
        logic [HUE_BITS-1:0] hue;
        hue   = i_t_quo + i_p_quo;
        n1_h6 = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
    end

    // Stage 2: sector plus rising and falling ramps, rounded half up
    logic                r2_valid;
    t_sector             r2_sector;
    t_chan               r2_up, r2_dn, n2_up, n2_dn;
    logic [FADE_W-1:0]   r2_fade;

    always_comb begin
        logic [RAMP_W-1:0] f;
        logic [RAMP_W-1:0] g;
        logic [RAMP_W-1:0] up_p;
        logic [RAMP_W-1:0] dn_p;
        f     = RAMP_W'(r1_h6[HUE_BITS-1:0]);
        g     = ONE - f;
        up_p  = (f << 8) - f + HALF;
        dn_p  = (g << 8) - g + HALF;
        n2_up = up_p[HUE_BITS+7:HUE_BITS];
        n2_dn = dn_p[HUE_BITS+7:HUE_BITS];
    end

    // Stage 3: colour select and fade
    logic   r3_valid;
    t_chan  r3_red, r3_green, r3_blue, n3_red, n3_green, n3_blue;

    always_comb begin
        t_chan r, g, b;
        unique case (r2_sector)
            SEC_R2Y: begin r = CHAN_MAX;  g = r2_up;     b = CHAN_ZERO; end
            SEC_Y2G: begin r = r2_dn;     g = CHAN_MAX;  b = CHAN_ZERO; end
            SEC_G2C: begin r = CHAN_ZERO; g = CHAN_MAX;  b = r2_up;     end
            SEC_C2B: begin r = CHAN_ZERO; g = r2_dn;     b = CHAN_MAX;  end
            SEC_B2M: begin r = r2_up;     g = CHAN_ZERO; b = CHAN_MAX;  end
            default: begin r = CHAN_MAX;  g = CHAN_ZERO; b = r2_dn;     end
        endcase
        priority if (r2_fade == FADE_OFF) begin
            n3_red   = CHAN_ZERO;
            n3_green = CHAN_ZERO;
            n3_blue  = CHAN_ZERO;
        end else if (!r2_fade[FADE_W-1]) begin
            n3_red   = fade_scale(r, r2_fade[7:0]);
            n3_green = fade_scale(g, r2_fade[7:0]);
            n3_blue  = fade_scale(b, r2_fade[7:0]);
        end else begin
            // full or above: pass through
            n3_red   = r;
            n3_green = g;
            n3_blue  = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_h6     <= n1_h6;
        r1_fade   <= i_fade;
        r2_sector <= r1_h6[H6_W-1:HUE_BITS];
        r2_up     <= n2_up;
        r2_dn     <= n2_dn;
        r2_fade   <= r1_fade;
        r3_red    <= n3_red;
        r3_green  <= n3_green;
        r3_blue   <= n3_blue;
    end

    assign o_strobe = r3_valid;
    assign o_red    = r3_red;
    assign o_green  = r3_green;
    assign o_blue   = r3_blue;

endmodule

/* rtl/rpg_checker.sv */
// Port-level checks for the rainbow pixel generator, bound to the top level.
// Depends on rpg_pkg and rainbow_pixel_generator_core.

module rpg_checker #(
    parameter int HUE_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [rpg_pkg::FADE_W-1:0]  i_fade_level,
    input logic                        o_strobe,
    input logic [rpg_pkg::CHAN_W-1:0]  o_green,
    input logic [rpg_pkg::CHAN_W-1:0]  o_red,
    input logic [rpg_pkg::CHAN_W-1:0]  o_blue
);
    import rpg_pkg::*;

    localparam int NSTEPS  = ELAPSED_W + HUE_BITS;
    localparam int LATENCY = (NSTEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE + 3;

    // busy is high after every reset cycle and low after every cycle out of reset
    a_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    a_ready_after_reset: assert property (@(posedge i_clk) i_rst_n |=> !busy)
        else $error("busy still high outside reset");

    // every result beat comes from an earlier taken beat, delayed through the divider and colour stages
    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching input beat");

    a_fade_off_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && ($past(i_fade_level, LATENCY) == FADE_OFF)
        |-> (o_red == CHAN_ZERO) && (o_green == CHAN_ZERO) && (o_blue == CHAN_ZERO))
        else $error("faded-out pixel is not black");

    // at full fade or above the colour is fully saturated: one channel full, one off
    a_full_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(i_fade_level[FADE_W-1], LATENCY)
        |-> ((o_red == CHAN_MAX) || (o_green == CHAN_MAX) || (o_blue == CHAN_MAX))
         && ((o_red == CHAN_ZERO) || (o_green == CHAN_ZERO) || (o_blue == CHAN_ZERO)))
        else $error("unfaded pixel is not fully saturated");

endmodule

bind rainbow_pixel_generator_core rpg_checker #(
    .HUE_BITS (HUE_BITS)
) u_rpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_fade_level (i_fade_level),
    .o_strobe     (o_strobe),
    .o_green      (o_green),
    .o_red        (o_red),
    .o_blue       (o_blue)
);
